/* design/fcts_pkg.sv */
// Shared types and constants for the floppy controller Type 1 sequencer.
`default_nettype none
package fcts_pkg;

  localparam logic [2:0] SPINUP_PULSES = 3'd6;
  localparam logic [2:0] INDEX_MAX = 3'd7;

  // Bus item codes.
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;
  localparam logic [1:0] FUNC_INDEX = 2'd3;

  // Register select codes.
  localparam logic [1:0] ADDR_CMD    = 2'd0;
  localparam logic [1:0] ADDR_TRACK  = 2'd1;
  localparam logic [1:0] ADDR_SECTOR = 2'd2;
  localparam logic [1:0] ADDR_DATA   = 2'd3;

  // Status register bits.
  localparam logic [7:0] ST_BUSY  = 8'h01;
  localparam logic [7:0] ST_DRQ   = 8'h02;
  localparam logic [7:0] ST_CRC   = 8'h08;
  localparam logic [7:0] ST_MOTOR = 8'h80;

  // Command opcodes of interest (upper nibble).
  localparam logic [3:0] OP_RESTORE = 4'd0;
  localparam logic [3:0] OP_STEP_IN_A  = 4'd4;
  localparam logic [3:0] OP_STEP_IN_B  = 4'd5;
  localparam logic [3:0] OP_STEP_OUT_A = 4'd6;
  localparam logic [3:0] OP_STEP_OUT_B = 4'd7;

  localparam logic [7:0] RESTORE_TRACK = 8'hff;

  typedef enum logic [3:0] {
    SEQ_WAITING     = 4'd0,
    SEQ_BEGIN       = 4'd1,
    SEQ_SPIN        = 4'd2,
    SEQ_POST_SPIN   = 4'd3,
    SEQ_TEST_TRACK  = 4'd4,
    SEQ_TEST_DIR    = 4'd5,
    SEQ_TEST_HEAD   = 4'd6,
    SEQ_STEP_DELAY  = 4'd7,
    SEQ_TEST_VERIFY = 4'd8
  } seq_state_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       step_pulse;
    logic       step_inward;
  } result_t;

endpackage
`default_nettype wire

/* design/fcts_core.sv */
// Register file and Type 1 sequencer state; settles one item per cycle while item_en is high.
`default_nettype none
module fcts_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_en,
  input  wire logic [1:0]        func,
  input  wire logic [1:0]        address,
  input  wire logic [7:0]        write_data,
  input  wire logic              track_zero,
  output fcts_pkg::result_t      result
);

  fcts_pkg::seq_state_t seq_state_r, seq_state_nxt;
  fcts_pkg::seq_state_t resume_state_r, resume_state_nxt;
  logic [7:0] command_r, command_nxt;
  logic [7:0] track_r, track_nxt;
  logic [7:0] sector_r, sector_nxt;
  logic [7:0] data_r, data_nxt;
  logic [7:0] status_r, status_nxt;
  logic       pending_r, pending_nxt;
  logic       dir_in_r, dir_in_nxt;
  logic [7:0] target_r, target_nxt;
  logic [2:0] delay_r, delay_nxt;
  logic [2:0] index_r, index_nxt;
  logic       irq_r, irq_nxt;

  logic [3:0] op;
  logic [2:0] index_inc;

  assign op = command_r[7:4];
  assign index_inc = (index_r < fcts_pkg::INDEX_MAX) ? index_r + 3'd1 : index_r;

  always_comb begin
    seq_state_nxt    = seq_state_r;
    resume_state_nxt = resume_state_r;
    command_nxt      = command_r;
    track_nxt        = track_r;
    sector_nxt       = sector_r;
    data_nxt         = data_r;
    status_nxt       = status_r;
    pending_nxt      = pending_r;
    dir_in_nxt       = dir_in_r;
    target_nxt       = target_r;
    delay_nxt        = delay_r;
    index_nxt        = index_r;
    irq_nxt          = irq_r;
    result           = '0;

    case (func)
      fcts_pkg::FUNC_WRITE: begin
        case (address)
          fcts_pkg::ADDR_CMD: begin
            command_nxt = write_data;
            pending_nxt = 1'b1;
          end
          fcts_pkg::ADDR_TRACK:  track_nxt  = write_data;
          fcts_pkg::ADDR_SECTOR: sector_nxt = write_data;
          default:               data_nxt   = write_data;
        endcase
      end
      fcts_pkg::FUNC_READ: begin
        case (address)
          fcts_pkg::ADDR_CMD: begin
            result.read_data = status_r;
            irq_nxt = 1'b0;
          end
          fcts_pkg::ADDR_TRACK:  result.read_data = track_r;
          fcts_pkg::ADDR_SECTOR: result.read_data = sector_r;
          default:               result.read_data = data_r;
        endcase
      end
      fcts_pkg::FUNC_TICK: begin
        case (seq_state_r)
          fcts_pkg::SEQ_WAITING: begin
            if (pending_r) begin
              pending_nxt = 1'b0;
              if (!command_r[7]) seq_state_nxt = fcts_pkg::SEQ_BEGIN;
            end
          end
          fcts_pkg::SEQ_SPIN: status_nxt = status_r | fcts_pkg::ST_MOTOR;
          fcts_pkg::SEQ_BEGIN: begin
            status_nxt = (status_r | fcts_pkg::ST_BUSY) &
                         ~(fcts_pkg::ST_DRQ | fcts_pkg::ST_CRC);
            irq_nxt = 1'b0;
            seq_state_nxt = fcts_pkg::SEQ_POST_SPIN;
            if (!command_r[3] && (status_r & fcts_pkg::ST_MOTOR) == 8'h00) begin
              resume_state_nxt = fcts_pkg::SEQ_POST_SPIN;
              index_nxt = 3'd0;
              seq_state_nxt = fcts_pkg::SEQ_SPIN;
            end
          end
          fcts_pkg::SEQ_POST_SPIN: begin
            if (op == fcts_pkg::OP_RESTORE) begin
              track_nxt = fcts_pkg::RESTORE_TRACK;
              data_nxt = 8'h00;
            end else if (op == fcts_pkg::OP_STEP_IN_A || op == fcts_pkg::OP_STEP_IN_B) begin
              dir_in_nxt = 1'b1;
            end else if (op == fcts_pkg::OP_STEP_OUT_A ||
                         op == fcts_pkg::OP_STEP_OUT_B) begin
              dir_in_nxt = 1'b0;
            end
            // Restore and seek compare tracks; step commands go straight to stepping.
            if (op[3:1] == 3'd0) seq_state_nxt = fcts_pkg::SEQ_TEST_TRACK;
            else if (command_r[4]) seq_state_nxt = fcts_pkg::SEQ_TEST_DIR;
            else seq_state_nxt = fcts_pkg::SEQ_TEST_HEAD;
          end
          fcts_pkg::SEQ_TEST_TRACK: begin
            target_nxt = data_r;
            if (track_r == data_r) begin
              seq_state_nxt = fcts_pkg::SEQ_TEST_VERIFY;
            end else begin
              dir_in_nxt = (data_r > track_r);
              seq_state_nxt = fcts_pkg::SEQ_TEST_DIR;
            end
          end
          fcts_pkg::SEQ_TEST_DIR: begin
            track_nxt = dir_in_r ? track_r + 8'd1 : track_r - 8'd1;
            seq_state_nxt = fcts_pkg::SEQ_TEST_HEAD;
          end
          fcts_pkg::SEQ_TEST_HEAD: begin
            if (track_zero && !dir_in_r) begin
              track_nxt = 8'h00;
              seq_state_nxt = fcts_pkg::SEQ_TEST_VERIFY;
            end else begin
              result.step_pulse = 1'b1;
              result.step_inward = dir_in_r;
              delay_nxt = 3'd0;
              seq_state_nxt = fcts_pkg::SEQ_STEP_DELAY;
            end
          end
          fcts_pkg::SEQ_STEP_DELAY: begin
            if (delay_r == {1'b0, command_r[1:0]}) begin
              seq_state_nxt = (op[3:1] != 3'd0) ? fcts_pkg::SEQ_TEST_VERIFY
                                                : fcts_pkg::SEQ_TEST_TRACK;
            end
            delay_nxt = delay_r + 3'd1;
          end
          fcts_pkg::SEQ_TEST_VERIFY: begin
            irq_nxt = 1'b1;
            status_nxt = status_r & ~fcts_pkg::ST_BUSY;
            seq_state_nxt = fcts_pkg::SEQ_WAITING;
          end
          default: seq_state_nxt = fcts_pkg::SEQ_WAITING;
        endcase
      end
      default: begin
        index_nxt = index_inc;
        if (seq_state_r == fcts_pkg::SEQ_SPIN && index_inc == fcts_pkg::SPINUP_PULSES) begin
          seq_state_nxt = resume_state_r;
        end
      end
    endcase
    result.irq = irq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_state_r    <= fcts_pkg::SEQ_WAITING;
      resume_state_r <= fcts_pkg::SEQ_WAITING;
      command_r      <= '0;
      track_r        <= '0;
      sector_r       <= '0;
      data_r         <= '0;
      status_r       <= '0;
      pending_r      <= 1'b0;
      dir_in_r       <= 1'b0;
      target_r       <= '0;
      delay_r        <= '0;
      index_r        <= '0;
      irq_r          <= 1'b0;
    end else if (item_en) begin
      seq_state_r    <= seq_state_nxt;
      resume_state_r <= resume_state_nxt;
      command_r      <= command_nxt;
      track_r        <= track_nxt;
      sector_r       <= sector_nxt;
      data_r         <= data_nxt;
      status_r       <= status_nxt;
      pending_r      <= pending_nxt;
      dir_in_r       <= dir_in_nxt;
      target_r       <= target_nxt;
      delay_r        <= delay_nxt;
      index_r        <= index_nxt;
      irq_r          <= irq_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/fcts_outq.sv */
// Two-entry result register with skid slot between the core and the output port.
`default_nettype none
module fcts_outq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire fcts_pkg::result_t push_data,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output fcts_pkg::result_t      out_data
);

  fcts_pkg::result_t head_r, head_nxt;
  fcts_pkg::result_t tail_r, tail_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign full      = (count_r == 2'd2);
  assign out_data  = head_r;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    case (count_r)
      2'd0: begin
        if (push) begin
          head_nxt  = push_data;
          count_nxt = 2'd1;
        end
      end
      2'd1: begin
        if (push && pop) begin
          head_nxt = push_data;
        end else if (push) begin
          tail_nxt  = push_data;
          count_nxt = 2'd2;
        end else if (pop) begin
          count_nxt = 2'd0;
        end
      end
      default: begin
        if (pop) begin
          head_nxt  = tail_r;
          count_nxt = 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule
`default_nettype wire

/* design/floppy_controller_type1_sequencer.sv */
// Top level of the floppy controller register file and Type 1 sequencer.
//
//   Channel  Direction  Ports
//   in       input      in_valid, in_stall, in_func, in_address, in_write_data, in_track_zero
//   out      output     out_valid, out_stall, out_read_data, out_irq, out_step_pulse,
//                       out_step_inward
//
// Every accepted input beat is settled in the cycle it is taken: the register file
// and sequencer state update at that edge and the result beat is registered.
// The result waits in the output buffer while out_stall is high; one beat per
// cycle is sustained otherwise, as the sequencer takes a single combinational step.
// A two-entry output buffer lets a new beat enter while a result still waits;
// in_stall rises only when both entries are held by a stalled output.
// Reset is synchronous and active low; it clears all core registers and the buffer count.
`default_nettype none
module floppy_controller_type1_sequencer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_func,
  input  wire logic [1:0] in_address,
  input  wire logic [7:0] in_write_data,
  input  wire logic       in_track_zero,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_read_data,
  output logic            out_irq,
  output logic            out_step_pulse,
  output logic            out_step_inward
);

  logic              in_accept;
  logic              queue_full;
  fcts_pkg::result_t core_result;
  fcts_pkg::result_t out_result;

  // A beat is taken whenever the output buffer has a free entry.
  assign in_stall  = queue_full;
  assign in_accept = in_valid && !queue_full;

  fcts_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_en    (in_accept),
    .func       (in_func),
    .address    (in_address),
    .write_data (in_write_data),
    .track_zero (in_track_zero),
    .result     (core_result)
  );

  fcts_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (core_result),
    .full      (queue_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_result)
  );

  assign out_read_data   = out_result.read_data;
  assign out_irq         = out_result.irq;
  assign out_step_pulse  = out_result.step_pulse;
  assign out_step_inward = out_result.step_inward;

`ifndef ASSERT_OFF
  // A full buffer always has a result to offer.
  a_full_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid) else $error("input stalled with no pending result");

  // Each accepted beat leaves a result ready on the next cycle.
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid) else $error("accepted beat produced no result");

  // A step direction is reported only together with a step.
  a_dir_with_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_step_inward) |-> out_step_pulse)
    else $error("step direction without step pulse");

  // Register reads are the only beats that return data.
  a_data_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_func != fcts_pkg::FUNC_READ) |=>
      (out_read_data == 8'h00 || $past(out_valid && out_stall)))
    else $error("non-read beat returned data");
`endif

endmodule
`default_nettype wire

/* tb/fdc_scoreboard_pkg.sv */
// Scoreboard class with the bus-level prediction of the floppy controller sequencer.
package fdc_scoreboard_pkg;
  import fcts_pkg::*;

  // Opcodes 0 and 1 (restore and seek) work toward a target track; all above are steps.
  localparam bit [3:0] OP_SEEK = 4'd1;

  class fdc_scoreboard;
    result_t    expected_beats[$];
    int         errors;

    // Controller state as seen from the bus.
    seq_state_t seq_state;
    seq_state_t resume_state;
    bit [7:0]   cmd_r;
    bit [7:0]   track_r;
    bit [7:0]   sector_r;
    bit [7:0]   data_r;
    bit [7:0]   status_r;
    bit         cmd_pending;
    bit         step_in;
    bit [7:0]   target_trk;
    bit [2:0]   delay_cnt;
    bit [2:0]   index_cnt;
    bit         irq_r;

    function new();
      errors = 0;
      seq_state = SEQ_WAITING;
      resume_state = SEQ_WAITING;
      cmd_r = '0;
      track_r = '0;
      sector_r = '0;
      data_r = '0;
      status_r = '0;
      cmd_pending = 1'b0;
      step_in = 1'b0;
      target_trk = '0;
      delay_cnt = '0;
      index_cnt = '0;
      irq_r = 1'b0;
    endfunction

    function int outstanding();
      return expected_beats.size();
    endfunction

    // True when no command runs and none waits to be taken.
    function bit idle();
      return (seq_state == SEQ_WAITING) && !cmd_pending;
    endfunction

    // One sequencer tick; returns {step issued, step inward}.
    function bit [1:0] sequencer_tick(bit tz);
      bit [3:0] op;
      bit [1:0] step;
      op = cmd_r[7:4];
      step = 2'b00;
      case (seq_state)
        SEQ_WAITING: begin
          if (cmd_pending) begin
            cmd_pending = 1'b0;
            if (!cmd_r[7]) seq_state = SEQ_BEGIN;
          end
        end
        SEQ_SPIN: status_r = status_r | ST_MOTOR;
        SEQ_BEGIN: begin
          status_r = (status_r | ST_BUSY) & ~(ST_DRQ | ST_CRC);
          irq_r = 1'b0;
          seq_state = SEQ_POST_SPIN;
          if (!cmd_r[3] && ((status_r & ST_MOTOR) == 8'h00)) begin
            resume_state = SEQ_POST_SPIN;
            index_cnt = '0;
            seq_state = SEQ_SPIN;
          end
        end
        SEQ_POST_SPIN: begin
          if (op == OP_RESTORE) begin
            track_r = RESTORE_TRACK;
            data_r = 8'h00;
          end else if (op == OP_STEP_IN_A || op == OP_STEP_IN_B) begin
            step_in = 1'b1;
          end else if (op == OP_STEP_OUT_A || op == OP_STEP_OUT_B) begin
            step_in = 1'b0;
          end
          if (op <= OP_SEEK) seq_state = SEQ_TEST_TRACK;
          else seq_state = cmd_r[4] ? SEQ_TEST_DIR : SEQ_TEST_HEAD;
        end
        SEQ_TEST_TRACK: begin
          target_trk = data_r;
          if (track_r == target_trk) begin
            seq_state = SEQ_TEST_VERIFY;
          end else begin
            step_in = (target_trk > track_r);
            seq_state = SEQ_TEST_DIR;
          end
        end
        SEQ_TEST_DIR: begin
          track_r = step_in ? track_r + 8'd1 : track_r - 8'd1;
          seq_state = SEQ_TEST_HEAD;
        end
        SEQ_TEST_HEAD: begin
          if (tz && !step_in) begin
            track_r = 8'h00;
            seq_state = SEQ_TEST_VERIFY;
          end else begin
            step = {1'b1, step_in};
            delay_cnt = '0;
            seq_state = SEQ_STEP_DELAY;
          end
        end
        SEQ_STEP_DELAY: begin
          if (delay_cnt == {1'b0, cmd_r[1:0]})
            seq_state = (op > OP_SEEK) ? SEQ_TEST_VERIFY : SEQ_TEST_TRACK;
          delay_cnt = delay_cnt + 3'd1;
        end
        SEQ_TEST_VERIFY: begin
          irq_r = 1'b1;
          status_r = status_r & ~ST_BUSY;
          seq_state = SEQ_WAITING;
        end
        default: seq_state = SEQ_WAITING;
      endcase
      return step;
    endfunction

    // Accepted input beat: advance the state and queue the result it causes.
    function void note_request(bit [1:0] func, bit [1:0] addr, bit [7:0] wd, bit tz);
      result_t r;
      r = '0;
      case (func)
        FUNC_WRITE: begin
          case (addr)
            ADDR_CMD: begin
              cmd_r = wd;
              cmd_pending = 1'b1;
            end
            ADDR_TRACK:  track_r = wd;
            ADDR_SECTOR: sector_r = wd;
            ADDR_DATA:   data_r = wd;
          endcase
        end
        FUNC_READ: begin
          case (addr)
            ADDR_CMD: begin
              r.read_data = status_r;
              irq_r = 1'b0;
            end
            ADDR_TRACK:  r.read_data = track_r;
            ADDR_SECTOR: r.read_data = sector_r;
            ADDR_DATA:   r.read_data = data_r;
          endcase
        end
        FUNC_TICK: {r.step_pulse, r.step_inward} = sequencer_tick(tz);
        FUNC_INDEX: begin
          if (index_cnt < INDEX_MAX) index_cnt = index_cnt + 3'd1;
          if (seq_state == SEQ_SPIN && index_cnt == SPINUP_PULSES) seq_state = resume_state;
        end
      endcase
      r.irq = irq_r;
      expected_beats.push_back(r);
    endfunction

    function void report_field(string field, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
    endfunction

    // Accepted result beat: compare with the oldest expectation.
    function void check_reply(result_t got);
      result_t want;
      if (expected_beats.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual read_data %0h irq %0b step %0b in %0b",
                 $time, got.read_data, got.irq, got.step_pulse, got.step_inward);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      if (got.read_data !== want.read_data) report_field("read_data", want.read_data, got.read_data);
      if (got.irq !== want.irq) report_field("irq", want.irq, got.irq);
      if (got.step_pulse !== want.step_pulse)
        report_field("step_pulse", want.step_pulse, got.step_pulse);
      if (got.step_inward !== want.step_inward)
        report_field("step_inward", want.step_inward, got.step_inward);
    endfunction
  endclass

endpackage

/* tb/tb_top.sv */
// Top-level testbench for the floppy controller register file and Type 1 sequencer.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fcts_pkg::*;
  import fdc_scoreboard_pkg::*;

  // Random beats after the directed opening.
  localparam int RANDOM_BEATS = 1100;
  // Length of the single long receiver hold-off, in cycles.
  localparam int LONG_HOLD_CYCLES = 400;
  // Hard stop for the whole run; well above the slowest legal run.
  localparam int TIMEOUT_NS = 2000000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_func;
  logic [1:0] in_address;
  logic [7:0] in_write_data;
  logic       in_track_zero;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_read_data;
  logic       out_irq;
  logic       out_step_pulse;
  logic       out_step_inward;

  fdc_scoreboard sb;

  int beats_sent;
  int burst_left;
  bit long_hold_req;

  floppy_controller_type1_sequencer DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_address     (in_address),
    .in_write_data  (in_write_data),
    .in_track_zero  (in_track_zero),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_data  (out_read_data),
    .out_irq        (out_irq),
    .out_step_pulse (out_step_pulse),
    .out_step_inward(out_step_inward)
  );

  always #5 clk = ~clk;

  // Every input of the block starts at a known value before the first edge.
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_READ;
    in_address = ADDR_CMD;
    in_write_data = 8'h00;
    in_track_zero = 1'b0;
    out_stall = 1'b0;
    long_hold_req = 1'b0;
    beats_sent = 0;
    burst_left = 1;
    sb = new();
  end

  // Monitor. Inputs only move on the falling edge, so at the rising edge both
  // channels show the values that the block itself samples.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_request(in_func, in_address, in_write_data, in_track_zero);
      if (out_valid && !out_stall)
        sb.check_reply({out_read_data, out_irq, out_step_pulse, out_step_inward});
    end
  end

  // Receiver. It switches between stall patterns of random length: no stalls,
  // light and heavy random stalls, and a fixed rhythm. Once the sender asks for
  // it, it holds the output off for a long stretch so that both buffer entries
  // fill and the block has to stall its input.
  initial begin : receiver
    int mode;
    int seg_left;
    int phase;
    mode = 0;
    seg_left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 150);
        end
        seg_left--;
        phase++;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          2: out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= ((phase % 5) < 2);
        endcase
      end
    end
  end

  // Offer one beat from a falling edge and hold it until it is taken. The
  // sender works in bursts; at the end of a burst valid drops for a random pause.
  // Back-to-back beats keep valid high, so it is never lowered and raised in
  // the same step.
  task automatic send_beat(input bit [1:0] func, input bit [1:0] addr,
                           input bit [7:0] wd, input bit tz);
    in_valid <= 1'b1;
    in_func <= func;
    in_address <= addr;
    in_write_data <= wd;
    in_track_zero <= tz;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    beats_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      if ($urandom_range(0, 4) == 0) burst_left = $urandom_range(40, 120);
      else burst_left = $urandom_range(1, 12);
    end
  endtask

  // A beat with every field random, including the ones the operation ignores.
  task automatic send_noise();
    send_beat(2'($urandom), 2'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // Stop offering beats until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // Clock the sequencer until it goes idle or the tick budget runs out. Bus
  // reads, index pulses, stray beats and a command rewrite while busy are mixed
  // in. Track zero shows up now and then, which ends outward runs early.
  task automatic run_ticks(input int cap);
    int n;
    int pick;
    n = 0;
    while (!sb.idle() && n < cap) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_beat(FUNC_READ, 2'($urandom), 8'($urandom), 1'($urandom));
      end else if (pick < 12) begin
        send_beat(FUNC_INDEX, 2'($urandom), 8'($urandom), 1'($urandom));
      end else if (pick < 14) begin
        send_noise();
      end else if (pick < 16) begin
        send_beat(FUNC_WRITE, ADDR_CMD, 8'($urandom), 1'($urandom));
      end else begin
        send_beat(FUNC_TICK, 2'($urandom), 8'($urandom), ($urandom_range(0, 7) == 0));
        n++;
      end
    end
  endtask

  // One random scenario. Most are complete commands: set up the track and
  // target, write a command, clock it to completion and read back. The rest
  // are plain noise.
  task automatic random_scenario();
    int pick;
    bit [7:0] trk;
    bit [7:0] tgt;
    bit [7:0] cmd;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      repeat ($urandom_range(1, 6)) send_noise();
    end else begin
      if ($urandom_range(0, 9) < 6) begin
        trk = 8'($urandom);
        // Targets stay close to the head so that seeks finish within a few
        // dozen ticks; a few go anywhere, including across the wrap.
        if ($urandom_range(0, 19) == 0) tgt = 8'($urandom);
        else tgt = trk + 8'($urandom_range(0, 8)) - 8'd4;
        send_beat(FUNC_WRITE, ADDR_TRACK, trk, 1'($urandom));
        send_beat(FUNC_WRITE, ADDR_DATA, tgt, 1'($urandom));
      end
      if ($urandom_range(0, 4) == 0)
        send_beat(FUNC_WRITE, ADDR_SECTOR, 8'($urandom), 1'($urandom));
      // Commands with bit 7 set are the Type 2 and 3 and force-interrupt
      // families, which the sequencer drops.
      cmd = 8'($urandom);
      cmd[7] = ($urandom_range(0, 9) == 0);
      send_beat(FUNC_WRITE, ADDR_CMD, cmd, 1'($urandom));
      run_ticks(120);
      if ($urandom_range(0, 1) == 1)
        send_beat(FUNC_READ, ADDR_CMD, 8'($urandom), 1'($urandom));
      if ($urandom_range(0, 2) == 0)
        send_beat(FUNC_READ, 2'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  initial begin : stimulus
    int directed_beats;
    int scenarios;
    bit hold_done;
    scenarios = 0;
    hold_done = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening: registers read back zero after reset, then the
    // extreme bytes go in.
    send_beat(FUNC_READ, ADDR_CMD, 8'h00, 1'b0);
    send_beat(FUNC_READ, ADDR_SECTOR, 8'hff, 1'b1);
    send_beat(FUNC_WRITE, ADDR_SECTOR, 8'hff, 1'b0);
    send_beat(FUNC_WRITE, ADDR_TRACK, 8'h02, 1'b1);
    send_beat(FUNC_WRITE, ADDR_DATA, 8'h00, 1'b0);
    send_beat(FUNC_READ, ADDR_DATA, 8'hff, 1'b0);
    // Restore with the longest step delay while the motor is off: the
    // sequencer waits for spin-up, turning the motor on during the wait.
    send_beat(FUNC_WRITE, ADDR_CMD, 8'h03, 1'b0);
    repeat (3) send_beat(FUNC_TICK, ADDR_CMD, 8'h00, 1'b0);
    // Six pulses end the wait; the last two show the index count saturating.
    repeat (8) send_beat(FUNC_INDEX, ADDR_DATA, 8'hff, 1'b1);
    // The restore itself sets the track to all ones and clears the target.
    send_beat(FUNC_TICK, ADDR_TRACK, 8'h00, 1'b0);
    send_beat(FUNC_READ, ADDR_CMD, 8'h00, 1'b0);
    // Force interrupt written while busy replaces the running command and is
    // dropped once the sequencer takes it.
    send_beat(FUNC_WRITE, ADDR_CMD, 8'hd0, 1'b0);
    run_ticks(60);
    send_beat(FUNC_TICK, ADDR_CMD, 8'h00, 1'b1);
    send_beat(FUNC_READ, ADDR_CMD, 8'h00, 1'b0);
    directed_beats = beats_sent;

    while (beats_sent < directed_beats + RANDOM_BEATS) begin
      random_scenario();
      scenarios++;
      // Once in the run the receiver holds off for a long stretch while the
      // sender keeps offering beats.
      if (!hold_done && beats_sent > directed_beats + 400) begin
        long_hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (scenarios % 40 == 0) drain();
    end

    drain();
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule
